// ===== hw/rtl/positional_ordered_list_top_macros.svh =====
// ----------------------------------------------------------------------------
// Positional ordered list: assertion macros
// Shared assertion helpers, clocked on i_clk and held off during i_rst_n.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_TOP_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define POL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define POL_ASSERT_NOW(lbl, ante, cons, msg)
`define POL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list: package
// Sizes, operation and status codes, and types shared by the list modules.
// ----------------------------------------------------------------------------
package pol_pkg;

    // Storage size
    localparam int CAPACITY  = 16;
    localparam int DATA_BITS = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Field widths of the stream items
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 5;
    localparam int ST_W      = 2;
    localparam int OCNT_W    = 5;
    localparam int OIDX_W    = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    typedef logic [DATA_BITS-1:0] t_data;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_count;

    // One result item
    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [OCNT_W-1:0]  entry_count;
        logic [VALUE_W-1:0] entry_value;
        logic [OIDX_W-1:0]  entry_index;
        logic               last;
    } t_result;

    // Storage access request from the sequencer
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_data wr_data;
        logic  rd_en;
        t_addr rd_addr;
    } t_ram_req;

endpackage

// ===== hw/rtl/pol_ram.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list: entry storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pol_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port: data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/pol_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list: sequencer
// Decodes a request, moves entries one slot per cycle through the storage
// port, then writes the new entry or drops the old one and reports status.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_top_macros.svh"

module pol_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [pol_pkg::OP_W-1:0]    i_op,
    input  logic [pol_pkg::VALUE_W-1:0] i_value,
    input  logic [pol_pkg::POS_W-1:0]   i_position,
    output logic                        o_push,
    output pol_pkg::t_result            o_res,
    input  logic                        i_push_ready,
    output pol_pkg::t_ram_req           o_ram,
    input  pol_pkg::t_data              i_rd_data
);

    localparam int CMP_W = ((pol_pkg::POS_W > pol_pkg::CNT_W) ?
                            pol_pkg::POS_W : pol_pkg::CNT_W) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_RESP  = 2'd2;
    localparam logic [1:0] S_DUMP  = 2'd3;

    logic [1:0]                r_state, n_state;
    pol_pkg::t_count           r_count, n_count;
    pol_pkg::t_count           r_moves, n_moves;
    pol_pkg::t_count           r_idx, n_idx;
    pol_pkg::t_addr            r_rd_addr, n_rd_addr;
    pol_pkg::t_addr            r_wr_addr, n_wr_addr;
    pol_pkg::t_addr            r_slot, n_slot;
    logic                      r_pend, n_pend;
    logic                      r_is_ins, n_is_ins;
    pol_pkg::t_data            r_value, n_value;
    logic [pol_pkg::ST_W-1:0]  r_status, n_status;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             ins_pos_ok;
    logic             del_pos_ok;
    logic             is_full;
    logic             is_empty;

    // Position checks against the current count
    always_comb begin
        pos_ext    = CMP_W'(i_position);
        cnt_ext    = CMP_W'(r_count);
        ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
        del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
        is_full    = (r_count == pol_pkg::t_count'(pol_pkg::CAPACITY));
        is_empty   = (r_count == '0);
    end

    // Sequencer
    always_comb begin
        pol_pkg::t_addr slot;
        slot        = '0;
        n_state     = r_state;
        n_count     = r_count;
        n_moves     = r_moves;
        n_idx       = r_idx;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_slot      = r_slot;
        n_pend      = 1'b0;
        n_is_ins    = r_is_ins;
        n_value     = r_value;
        n_status    = r_status;
        o_req_ready = 1'b0;
        o_push      = 1'b0;
        o_res       = '0;
        o_ram       = '0;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    unique case (i_op) inside
                        pol_pkg::OP_INS_FIRST, pol_pkg::OP_INS_LAST,
                        pol_pkg::OP_INS_AT: begin
                            if (is_full) begin
                                n_status = pol_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else if (i_op == pol_pkg::OP_INS_AT && !ins_pos_ok) begin
                                n_status = pol_pkg::ST_BADPOS;
                                n_state  = S_RESP;
                            end else begin
                                if (i_op == pol_pkg::OP_INS_FIRST) begin
                                    slot = '0;
                                end else if (i_op == pol_pkg::OP_INS_LAST) begin
                                    slot = pol_pkg::t_addr'(r_count);
                                end else begin
                                    slot = pol_pkg::t_addr'(pos_ext - CMP_W'(1));
                                end
                                n_is_ins  = 1'b1;
                                n_slot    = slot;
                                n_rd_addr = pol_pkg::t_addr'(cnt_ext - CMP_W'(1));
                                n_moves   = r_count - pol_pkg::t_count'(slot);
                                n_value   = pol_pkg::t_data'(i_value);
                                n_state   = S_SHIFT;
                            end
                        end
                        pol_pkg::OP_DEL_FIRST, pol_pkg::OP_DEL_LAST,
                        pol_pkg::OP_DEL_AT: begin
                            if (is_empty) begin
                                n_status = pol_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else if (i_op == pol_pkg::OP_DEL_AT && !del_pos_ok) begin
                                n_status = pol_pkg::ST_BADPOS;
                                n_state  = S_RESP;
                            end else begin
                                if (i_op == pol_pkg::OP_DEL_FIRST) begin
                                    slot = '0;
                                end else if (i_op == pol_pkg::OP_DEL_LAST) begin
                                    slot = pol_pkg::t_addr'(cnt_ext - CMP_W'(1));
                                end else begin
                                    slot = pol_pkg::t_addr'(pos_ext - CMP_W'(1));
                                end
                                n_is_ins  = 1'b0;
                                n_slot    = slot;
                                n_rd_addr = slot + pol_pkg::t_addr'(1);
                                n_moves   = r_count - pol_pkg::t_count'(1)
                                            - pol_pkg::t_count'(slot);
                                n_state   = S_SHIFT;
                            end
                        end
                        pol_pkg::OP_DUMP: begin
                            if (is_empty) begin
                                n_status = pol_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                o_ram.rd_en   = 1'b1;
                                o_ram.rd_addr = '0;
                                n_idx         = pol_pkg::t_count'(1);
                                n_state       = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = pol_pkg::ST_OK;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // Issue the next move read; step down for an insert, up for a delete
                if (r_moves != '0) begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_rd_addr;
                    n_moves       = r_moves - pol_pkg::t_count'(1);
                    n_pend        = 1'b1;
                    if (r_is_ins) begin
                        n_rd_addr = r_rd_addr - pol_pkg::t_addr'(1);
                        n_wr_addr = r_rd_addr + pol_pkg::t_addr'(1);
                    end else begin
                        n_rd_addr = r_rd_addr + pol_pkg::t_addr'(1);
                        n_wr_addr = r_rd_addr - pol_pkg::t_addr'(1);
                    end
                end
                // Write back the entry read last cycle
                if (r_pend) begin
                    o_ram.wr_en   = 1'b1;
                    o_ram.wr_addr = r_wr_addr;
                    o_ram.wr_data = i_rd_data;
                end
                // Finish: place the new entry or drop the old one
                if (r_moves == '0 && !r_pend) begin
                    if (r_is_ins) begin
                        o_ram.wr_en   = 1'b1;
                        o_ram.wr_addr = r_slot;
                        o_ram.wr_data = r_value;
                        n_count       = r_count + pol_pkg::t_count'(1);
                    end else begin
                        n_count = r_count - pol_pkg::t_count'(1);
                    end
                    n_status = pol_pkg::ST_OK;
                    n_state  = S_RESP;
                end
            end

            S_RESP: begin
                o_push            = 1'b1;
                o_res.status      = r_status;
                o_res.entry_count = pol_pkg::OCNT_W'(r_count);
                o_res.last        = 1'b1;
                if (i_push_ready) begin
                    n_state = S_IDLE;
                end
            end

            S_DUMP: begin
                // Hand out the entry held on the read port, fetch the next
                o_push            = 1'b1;
                o_res.status      = pol_pkg::ST_OK;
                o_res.entry_count = pol_pkg::OCNT_W'(r_count);
                o_res.entry_value = pol_pkg::VALUE_W'(i_rd_data);
                o_res.entry_index = pol_pkg::OIDX_W'(r_idx);
                o_res.last        = (r_idx == r_count);
                if (i_push_ready) begin
                    if (r_idx == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram.rd_en   = 1'b1;
                        o_ram.rd_addr = pol_pkg::t_addr'(r_idx);
                        n_idx         = r_idx + pol_pkg::t_count'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_moves   <= n_moves;
        r_idx     <= n_idx;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_slot    <= n_slot;
        r_is_ins  <= n_is_ins;
        r_value   <= n_value;
        r_status  <= n_status;
    end

    `POL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= pol_pkg::t_count'(pol_pkg::CAPACITY), "count above capacity")
    `POL_ASSERT_NOW(a_port_clash, o_ram.wr_en && o_ram.rd_en, o_ram.wr_addr != o_ram.rd_addr, "read and write hit one slot")
    `POL_ASSERT_NOW(a_dump_index, o_push && o_res.entry_index != '0, o_res.entry_index <= pol_pkg::OIDX_W'(r_count), "dump index beyond count")
    `POL_ASSERT_NOW(a_dump_last, o_push && o_res.last && o_res.entry_index != '0, o_res.entry_index == pol_pkg::OIDX_W'(r_count), "dump ends early")
    `POL_ASSERT_NEXT(a_busy, i_req_valid && o_req_ready, r_state != S_IDLE, "request taken but still idle")

endmodule

// ===== hw/rtl/pol_out.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list: result register
// Holds one result item for the master side so the sequencer can run ahead.
// ----------------------------------------------------------------------------
module pol_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pol_pkg::t_result i_res,
    output logic             o_push_ready,
    output logic             o_valid,
    output pol_pkg::t_result o_res,
    input  logic             i_ready
);

    logic             r_valid;
    pol_pkg::t_result r_res;

    assign o_push_ready = !r_valid || i_ready;

    // Hold the item until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_push_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push_ready && i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/positional_ordered_list_top.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list: top level
// Ordered list of up to 16 words with positional insert, delete and dump.
// ----------------------------------------------------------------------------
// The block takes one request at a time. It is not ready again until its
// reply has been handed to the result register. Entries sit packed in a RAM
// with one read and one write port, and later entries move one slot per
// cycle through those ports. An insert at list slot s (0-based) with n
// entries held moves m = n-s entries. A delete moves m = n-1-s entries.
// After the moves, the sequencer writes the new entry or drops the old one
// and hands the status reply to the result register, which puts it on the
// master side. A rejected request, or the spare op code, moves nothing and
// goes straight to its status reply. A dump of n entries reads the first
// entry in the accepting cycle. It then delivers one entry per cycle while
// the sink keeps up. A sink that holds off stalls the sequencer on its
// pending reply once the result register is full. The result register
// lets the last reply wait while the next request is taken.
module positional_ordered_list_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] value, [36:32] position, [39:37] zero
    input  logic [pol_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] op
    input  logic [pol_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [4:0] entry_count, [36:5] entry_value, [41:37] entry_index, [47:42] zero
    output logic [pol_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [pol_pkg::ST_W-1:0]         m_axis_tuser,
    output logic                             m_axis_tlast
);

    pol_pkg::t_result  res_push;
    pol_pkg::t_result  res_out;
    pol_pkg::t_ram_req ram_req;
    pol_pkg::t_data    rd_data;
    logic              push;
    logic              push_ready;

    pol_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_value      (s_axis_tdata[31:0]),
        .i_position   (s_axis_tdata[36:32]),
        .o_push       (push),
        .o_res        (res_push),
        .i_push_ready (push_ready),
        .o_ram        (ram_req),
        .i_rd_data    (rd_data)
    );

    pol_ram #(
        .DEPTH (pol_pkg::CAPACITY),
        .WIDTH (pol_pkg::DATA_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    pol_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_res        (res_push),
        .o_push_ready (push_ready),
        .o_valid      (m_axis_tvalid),
        .o_res        (res_out),
        .i_ready      (m_axis_tready)
    );

    // Pack the result item onto the master side
    assign m_axis_tdata = {6'd0, res_out.entry_index, res_out.entry_value,
                           res_out.entry_count};
    assign m_axis_tuser = res_out.status;
    assign m_axis_tlast = res_out.last;

endmodule

// ===== tb/tb_positional_ordered_list_top.sv =====
// ----------------------------------------------------------------------------
// Positional ordered list: testbench
// Sends list requests over the input stream and checks every reply item
// against a predicted copy of the list. A short directed part covers the
// empty and bad-position cases. Random episodes then fill, drain and
// mix requests under three sender/receiver idle patterns. Somewhere in that
// random part the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list_top;

    // Spare operation code: no change, plain status reply
    localparam logic [pol_pkg::OP_W-1:0] OP_NOP = 3'd7;

    // Scoreboard: predicted list contents and queue of awaited reply items
    class list_scoreboard;
        pol_pkg::t_data   slots[pol_pkg::CAPACITY];
        int               count;
        pol_pkg::t_result awaited[$];
        int unsigned      failures;

        function int held();
            return count;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void push_status(logic [pol_pkg::ST_W-1:0] st);
            pol_pkg::t_result r;
            r.status      = st;
            r.entry_count = pol_pkg::OCNT_W'(count);
            r.entry_value = '0;
            r.entry_index = '0;
            r.last        = 1'b1;
            awaited.push_back(r);
        endfunction

        // Apply one accepted request and queue its reply items
        function void note_request(logic [pol_pkg::OP_W-1:0] op,
                                   logic [pol_pkg::VALUE_W-1:0] value,
                                   logic [pol_pkg::POS_W-1:0] pos);
            logic [pol_pkg::ST_W-1:0] st;
            pol_pkg::t_result         r;
            int                       slot;
            int                       i;
            st = pol_pkg::ST_OK;
            case (op)
                pol_pkg::OP_INS_FIRST, pol_pkg::OP_INS_LAST, pol_pkg::OP_INS_AT: begin
                    if (count >= pol_pkg::CAPACITY) begin
                        st = pol_pkg::ST_FULL;
                    end else begin
                        if (op == pol_pkg::OP_INS_FIRST) slot = 0;
                        else if (op == pol_pkg::OP_INS_LAST) slot = count;
                        else if (pos < 1 || pos > count + 1) slot = -1;
                        else slot = int'(pos) - 1;
                        if (slot < 0) begin
                            st = pol_pkg::ST_BADPOS;
                        end else begin
                            for (i = count; i > slot; i--) slots[i] = slots[i-1];
                            slots[slot] = value;
                            count++;
                        end
                    end
                end
                pol_pkg::OP_DEL_FIRST, pol_pkg::OP_DEL_LAST, pol_pkg::OP_DEL_AT: begin
                    if (count == 0) begin
                        st = pol_pkg::ST_EMPTY;
                    end else begin
                        if (op == pol_pkg::OP_DEL_FIRST) slot = 0;
                        else if (op == pol_pkg::OP_DEL_LAST) slot = count - 1;
                        else if (pos < 1 || pos > count) slot = -1;
                        else slot = int'(pos) - 1;
                        if (slot < 0) begin
                            st = pol_pkg::ST_BADPOS;
                        end else begin
                            for (i = slot; i + 1 < count; i++) slots[i] = slots[i+1];
                            count--;
                        end
                    end
                end
                pol_pkg::OP_DUMP: begin
                    if (count == 0) begin
                        st = pol_pkg::ST_EMPTY;
                    end else begin
                        for (i = 0; i < count; i++) begin
                            r.status      = pol_pkg::ST_OK;
                            r.entry_count = pol_pkg::OCNT_W'(count);
                            r.entry_value = slots[i];
                            r.entry_index = pol_pkg::OIDX_W'(i + 1);
                            r.last        = (i + 1 == count);
                            awaited.push_back(r);
                        end
                        return;
                    end
                end
                default: ;
            endcase
            push_status(st);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            failures++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field, want, got);
        endfunction

        // Compare one accepted reply item with the oldest awaited one
        function void check_result(logic [pol_pkg::OUT_DATA_W-1:0] data,
                                   logic [pol_pkg::ST_W-1:0] st, logic lst);
            pol_pkg::t_result want;
            if (awaited.size() == 0) begin
                failures++;
                $display("%0t: unexpected reply: expected none, actual data %0h status %0h",
                         $time, data, st);
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status) report("status", want.status, st);
            if (data[4:0] !== want.entry_count)
                report("entry_count", want.entry_count, data[4:0]);
            if (data[36:5] !== want.entry_value)
                report("entry_value", want.entry_value, data[36:5]);
            if (data[41:37] !== want.entry_index)
                report("entry_index", want.entry_index, data[41:37]);
            if (lst !== want.last) report("last", want.last, lst);
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [pol_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] value, [36:32] position
    logic [pol_pkg::OP_W-1:0]       s_axis_tuser  = '0;   // [2:0] op
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [pol_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // [4:0] count, [36:5] value, [41:37] index
    logic [pol_pkg::ST_W-1:0]       m_axis_tuser;  // [1:0] status
    logic                           m_axis_tlast;

    list_scoreboard sb = new();
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_req      = 0;

    positional_ordered_list_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Give up on a hung run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receive replies: check each, then pick the next ready level
    initial begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (!hold_taken && hold_req != 0) begin
                hold_left  = hold_req;
                hold_taken = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one request, idling first at random, and note it once taken
    task automatic send_request(logic [pol_pkg::OP_W-1:0] op,
                                logic [pol_pkg::VALUE_W-1:0] value,
                                logic [pol_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, pos, value};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, value, pos);
    endtask

    function automatic logic [pol_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Position inside the legal range most of the time, anything otherwise
    function automatic logic [pol_pkg::POS_W-1:0] pick_pos(int top);
        if (top < 1 || $urandom_range(9) < 2) return pol_pkg::POS_W'($urandom_range(31));
        return pol_pkg::POS_W'($urandom_range(1, top));
    endfunction

    // Random episodes: fill towards full, drain towards empty, or mix
    task automatic run_random(int budget);
        logic [pol_pkg::OP_W-1:0] op;
        int                       len;
        int                       n;
        while (budget > 0) begin
            case ($urandom_range(2))
                0: begin
                    len = pol_pkg::CAPACITY - sb.held() + $urandom_range(1, 3);
                    for (n = 0; n < len; n++) begin
                        op = pol_pkg::OP_W'($urandom_range(2));
                        send_request(op, pick_value(), pick_pos(sb.held() + 1));
                    end
                end
                1: begin
                    len = sb.held() + $urandom_range(1, 2);
                    for (n = 0; n < len; n++) begin
                        op = pol_pkg::OP_W'($urandom_range(3, 5));
                        send_request(op, pick_value(), pick_pos(sb.held()));
                    end
                end
                default: begin
                    len = $urandom_range(8, 20);
                    for (n = 0; n < len; n++) begin
                        op = pol_pkg::OP_W'($urandom_range(7));
                        if (op == pol_pkg::OP_INS_AT)
                            send_request(op, pick_value(), pick_pos(sb.held() + 1));
                        else
                            send_request(op, pick_value(), pick_pos(sb.held()));
                    end
                end
            endcase
            send_request(pol_pkg::OP_DUMP, pick_value(), pick_pos(0));
            budget -= len + 1;
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, bad positions, sole entry, field extremes
        send_request(pol_pkg::OP_DUMP,      32'h0,         5'd0);
        send_request(pol_pkg::OP_DEL_FIRST, 32'h0,         5'd0);
        send_request(pol_pkg::OP_DEL_LAST,  32'h0,         5'd0);
        send_request(pol_pkg::OP_DEL_AT,    32'h0,         5'd0);
        send_request(pol_pkg::OP_INS_AT,    32'h1234_5678, 5'd0);
        send_request(pol_pkg::OP_INS_AT,    32'h1234_5678, 5'd2);
        send_request(pol_pkg::OP_INS_AT,    32'h0,         5'd1);
        send_request(pol_pkg::OP_DEL_AT,    32'h0,         5'd1);
        send_request(pol_pkg::OP_INS_LAST,  32'hFFFF_FFFF, 5'd0);
        send_request(pol_pkg::OP_INS_FIRST, 32'h0,         5'd31);
        send_request(pol_pkg::OP_INS_AT,    32'hA5A5_A5A5, 5'd3);
        send_request(pol_pkg::OP_INS_AT,    32'h5A5A_5A5A, 5'd2);
        send_request(pol_pkg::OP_INS_AT,    32'hFFFF_FFFF, 5'd31);
        send_request(pol_pkg::OP_DEL_AT,    32'hFFFF_FFFF, 5'd0);
        send_request(pol_pkg::OP_DEL_AT,    32'h0,         5'd5);
        send_request(pol_pkg::OP_DUMP,      32'h0,         5'd0);
        send_request(OP_NOP,                32'hFFFF_FFFF, 5'd31);
        send_request(pol_pkg::OP_DEL_AT,    32'h0,         5'd2);
        send_request(pol_pkg::OP_DEL_LAST,  32'h0,         5'd0);
        send_request(pol_pkg::OP_DEL_FIRST, 32'h0,         5'd0);
        send_request(pol_pkg::OP_DUMP,      32'h0,         5'd0);
        send_request(pol_pkg::OP_DEL_LAST,  32'h0,         5'd0);

        // Random: slow receiver with one long hold-off, then slow sender, then none
        src_idle_pct = 24;
        sink_idle_pct <= 70;
        hold_req <= 600;
        run_random(130);
        src_idle_pct = 70;
        sink_idle_pct <= 24;
        run_random(130);
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        run_random(120);
        s_axis_tvalid <= 1'b0;

        // Drain outstanding replies, then allow for stray ones
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pol_pkg.sv
hw/rtl/pol_ram.sv
hw/rtl/pol_ctrl.sv
hw/rtl/pol_out.sv
hw/rtl/positional_ordered_list_top.sv
tb/tb_positional_ordered_list_top.sv
